>>> hw/rtl/lss_pkg.sv
// shared types, sizes and index tables of the 3x3 linear solver
package lss_pkg;

   // coordinate and arithmetic sizes
   localparam int unsigned COORD_WIDTH = 16;
   localparam int unsigned PAIR_W      = 2 * COORD_WIDTH;
   localparam int unsigned PROD_W      = 3 * COORD_WIDTH;
   localparam int unsigned SUM_W       = PROD_W + 3;
   localparam int unsigned OUT_FRAC    = 16;
   localparam int unsigned SOL_W       = 32;
   localparam int unsigned DIV_W       = SUM_W + SOL_W + 2;
   localparam int unsigned THR_W       = 48;
   localparam int unsigned NUM_BOX     = 4;
   localparam int unsigned NUM_TERM    = 6;
   localparam int unsigned NUM_LANE    = 3;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);

   // vector slots: column 1, column 2, column 3, right-hand side
   localparam int unsigned VEC_C1  = 0;
   localparam int unsigned VEC_C2  = 1;
   localparam int unsigned VEC_C3  = 2;
   localparam int unsigned VEC_RHS = 3;

   // triple products u.(v x w): determinant, then the x, y and z numerators
   localparam int unsigned BOX_U [NUM_BOX] = '{VEC_C1, VEC_RHS, VEC_RHS, VEC_RHS};
   localparam int unsigned BOX_V [NUM_BOX] = '{VEC_C2, VEC_C2, VEC_C3, VEC_C1};
   localparam int unsigned BOX_W [NUM_BOX] = '{VEC_C3, VEC_C3, VEC_C1, VEC_C2};

   // component picks of the six terms, first three added, last three subtracted
   localparam int unsigned TERM_U [NUM_TERM] = '{0, 1, 2, 2, 1, 0};
   localparam int unsigned TERM_V [NUM_TERM] = '{1, 2, 0, 1, 0, 2};
   localparam int unsigned TERM_W [NUM_TERM] = '{2, 0, 1, 0, 2, 1};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] col1_x;
      logic signed [COORD_WIDTH-1:0] col1_y;
      logic signed [COORD_WIDTH-1:0] col1_z;
      logic signed [COORD_WIDTH-1:0] col2_x;
      logic signed [COORD_WIDTH-1:0] col2_y;
      logic signed [COORD_WIDTH-1:0] col2_z;
      logic signed [COORD_WIDTH-1:0] col3_x;
      logic signed [COORD_WIDTH-1:0] col3_y;
      logic signed [COORD_WIDTH-1:0] col3_z;
      logic signed [COORD_WIDTH-1:0] rhs_x;
      logic signed [COORD_WIDTH-1:0] rhs_y;
      logic signed [COORD_WIDTH-1:0] rhs_z;
   } req_type;

   typedef struct packed {
      logic signed [SOL_W-1:0] sol_x;
      logic signed [SOL_W-1:0] sol_y;
      logic signed [SOL_W-1:0] sol_z;
      logic                    solvable;
      logic                    saturated;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic                               singular;
      logic [NUM_LANE-1:0]                neg;
      logic [NUM_LANE-1:0][SUM_W-1:0]     num_mag;
      logic [SUM_W-1:0]                   det_mag;
   } job_type;

   // control travelling alongside the divider lanes
   typedef struct packed {
      logic                valid;
      logic                singular;
      logic [NUM_LANE-1:0] neg;
   } ctrl_type;

endpackage

>>> hw/rtl/lss_front.sv
// front end: triple products, determinant and singularity classification
module lss_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  lss_pkg::req_type                 in_req,
   input  logic [lss_pkg::THR_W-1:0]        threshold,
   output logic                             out_valid,
   output lss_pkg::job_type                 out_job
);

   localparam int unsigned CW = lss_pkg::COORD_WIDTH;

   logic                      v0_ff, va_ff, vb_ff, vc_ff;
   lss_pkg::req_type          req_ff;
   logic signed [CW-1:0]      vec [4][3];
   logic signed [lss_pkg::PAIR_W-1:0] pair_ff [lss_pkg::NUM_BOX][lss_pkg::NUM_TERM];
   logic signed [CW-1:0]      last_ff [lss_pkg::NUM_BOX][lss_pkg::NUM_TERM];
   logic signed [lss_pkg::PROD_W-1:0] tri_ff [lss_pkg::NUM_BOX][lss_pkg::NUM_TERM];
   logic signed [lss_pkg::SUM_W-1:0]  sum_in [lss_pkg::NUM_BOX];
   logic signed [lss_pkg::SUM_W-1:0]  sum_ff [lss_pkg::NUM_BOX];
   logic [lss_pkg::SUM_W-1:0] det_mag;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         va_ff <= v0_ff;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (in_valid) begin
         req_ff <= in_req;
      end
   end

   // vectors by slot
   always_comb begin
      vec[lss_pkg::VEC_C1]  = '{req_ff.col1_x, req_ff.col1_y, req_ff.col1_z};
      vec[lss_pkg::VEC_C2]  = '{req_ff.col2_x, req_ff.col2_y, req_ff.col2_z};
      vec[lss_pkg::VEC_C3]  = '{req_ff.col3_x, req_ff.col3_y, req_ff.col3_z};
      vec[lss_pkg::VEC_RHS] = '{req_ff.rhs_x, req_ff.rhs_y, req_ff.rhs_z};
   end

   // first and second multiplication of every term
   for (genvar b = 0; b < lss_pkg::NUM_BOX; b++) begin : g_box
      for (genvar t = 0; t < lss_pkg::NUM_TERM; t++) begin : g_term
         always_ff @(posedge clock) begin
            pair_ff[b][t] <= lss_pkg::PAIR_W'(vec[lss_pkg::BOX_U[b]][lss_pkg::TERM_U[t]])
                           * lss_pkg::PAIR_W'(vec[lss_pkg::BOX_V[b]][lss_pkg::TERM_V[t]]);
            last_ff[b][t] <= vec[lss_pkg::BOX_W[b]][lss_pkg::TERM_W[t]];
            tri_ff[b][t]  <= lss_pkg::PROD_W'(pair_ff[b][t])
                           * lss_pkg::PROD_W'(last_ff[b][t]);
         end
      end
   end

   // signed sum of the six terms
   always_comb begin
      for (int b = 0; b < lss_pkg::NUM_BOX; b++) begin
         sum_in[b] = '0;
         for (int t = 0; t < lss_pkg::NUM_TERM; t++) begin
            if (t < 3) begin
               sum_in[b] = sum_in[b] + lss_pkg::SUM_W'(tri_ff[b][t]);
            end else begin
               sum_in[b] = sum_in[b] - lss_pkg::SUM_W'(tri_ff[b][t]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // classification
   always_comb begin
      det_mag = sum_ff[0][lss_pkg::SUM_W-1] ? lss_pkg::SUM_W'(-sum_ff[0])
                                            : lss_pkg::SUM_W'(sum_ff[0]);
      out_job.det_mag  = det_mag;
      out_job.singular = (det_mag == '0) || (det_mag < lss_pkg::SUM_W'(threshold));
      for (int k = 0; k < lss_pkg::NUM_LANE; k++) begin
         out_job.neg[k]     = sum_ff[k+1][lss_pkg::SUM_W-1] ^ sum_ff[0][lss_pkg::SUM_W-1];
         out_job.num_mag[k] = sum_ff[k+1][lss_pkg::SUM_W-1] ? lss_pkg::SUM_W'(-sum_ff[k+1])
                                                            : lss_pkg::SUM_W'(sum_ff[k+1]);
      end
   end

   assign out_valid = vc_ff;

endmodule

>>> hw/rtl/lss_queue.sv
// short request queue between front and back
module lss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lss_pkg::job_type push_job,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output lss_pkg::job_type head_job
);

   localparam int unsigned PTR_W = $clog2(lss_pkg::QUEUE_DEPTH);

   lss_pkg::job_type        entry_ff [lss_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]          count_ff;
   logic                    do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (PTR_W+1)'(lss_pkg::QUEUE_DEPTH));
   assign do_pop    = pop && not_empty;
   assign head_job  = entry_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(push && !full) - (PTR_W+1)'(do_pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("request pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(lss_pkg::QUEUE_DEPTH)) else $error("queue fill out of range");

endmodule

>>> hw/rtl/lss_div_lane.sv
// one pipelined restoring divider lane, one quotient bit per stage
module lss_div_lane (
   input  logic                          clock,
   input  logic [lss_pkg::SUM_W-1:0]     in_num,
   input  logic [lss_pkg::SUM_W-1:0]     in_det,
   output logic [lss_pkg::SOL_W-1:0]     out_quot,
   output logic                          out_ovf
);

   localparam int unsigned NST = lss_pkg::SOL_W;

   logic [lss_pkg::DIV_W-1:0] rem_ff [NST+1];
   logic [lss_pkg::DIV_W-1:0] div_ff [NST+1];
   logic [lss_pkg::SOL_W-1:0] quot_ff [NST+1];
   logic                      ovf_ff [NST+1];
   logic [lss_pkg::DIV_W-1:0] rem_in, div_in;

   // rounded dividend and doubled divisor, overflow check up front
   always_comb begin
      rem_in = (lss_pkg::DIV_W'(in_num) << (lss_pkg::OUT_FRAC + 1))
             + lss_pkg::DIV_W'(in_det);
      div_in = lss_pkg::DIV_W'(in_det) << 1;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= rem_in;
      div_ff[0]  <= div_in;
      quot_ff[0] <= '0;
      ovf_ff[0]  <= rem_in >= (div_in << NST);
   end

   // one quotient bit per stage, most significant first
   for (genvar s = 1; s <= NST; s++) begin : g_stage
      logic [lss_pkg::DIV_W-1:0] trial;
      assign trial = div_ff[s-1] << (NST - s);
      always_ff @(posedge clock) begin
         div_ff[s] <= div_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
         if (rem_ff[s-1] >= trial) begin
            rem_ff[s]  <= rem_ff[s-1] - trial;
            quot_ff[s] <= quot_ff[s-1] | (lss_pkg::SOL_W'(1) << (NST - s));
         end else begin
            rem_ff[s]  <= rem_ff[s-1];
            quot_ff[s] <= quot_ff[s-1];
         end
      end
   end

   assign out_quot = quot_ff[NST];
   assign out_ovf  = ovf_ff[NST];

endmodule

>>> hw/rtl/lss_back.sv
// back end: three divider lanes, rounding, saturation and result register
module lss_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  lss_pkg::job_type in_job,
   output logic             out_strobe,
   output lss_pkg::rsp_type out_rsp
);

   localparam int unsigned NST = lss_pkg::SOL_W;

   lss_pkg::ctrl_type          ctrl_ff [NST+1];
   logic [lss_pkg::SOL_W-1:0]  quot [lss_pkg::NUM_LANE];
   logic                       ovf  [lss_pkg::NUM_LANE];
   logic [lss_pkg::SOL_W-1:0]  sol_in [lss_pkg::NUM_LANE];
   logic [lss_pkg::NUM_LANE-1:0] sat_in;
   logic                       strobe_ff;
   lss_pkg::rsp_type           rsp_ff;

   for (genvar k = 0; k < lss_pkg::NUM_LANE; k++) begin : g_lane
      lss_div_lane u_lane (
         .clock    (clock),
         .in_num   (in_job.num_mag[k]),
         .in_det   (in_job.det_mag),
         .out_quot (quot[k]),
         .out_ovf  (ovf[k])
      );
   end

   // control alongside the lanes, only the valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NST; s++) begin
            ctrl_ff[s].valid <= 1'b0;
         end
      end else begin
         ctrl_ff[0].valid <= in_valid;
         for (int s = 1; s <= NST; s++) begin
            ctrl_ff[s].valid <= ctrl_ff[s-1].valid;
         end
      end
      ctrl_ff[0].singular <= in_job.singular;
      ctrl_ff[0].neg      <= in_job.neg;
      for (int s = 1; s <= NST; s++) begin
         ctrl_ff[s].singular <= ctrl_ff[s-1].singular;
         ctrl_ff[s].neg      <= ctrl_ff[s-1].neg;
      end
   end

   // clip to the signed range and restore the sign
   always_comb begin
      for (int k = 0; k < lss_pkg::NUM_LANE; k++) begin
         logic [lss_pkg::SOL_W-1:0] lim;
         logic [lss_pkg::SOL_W-1:0] mag;
         lim = ctrl_ff[NST].neg[k] ? {1'b1, {(lss_pkg::SOL_W-1){1'b0}}}
                                   : {1'b0, {(lss_pkg::SOL_W-1){1'b1}}};
         sat_in[k] = ovf[k] || (quot[k] > lim);
         mag       = sat_in[k] ? lim : quot[k];
         sol_in[k] = ctrl_ff[NST].neg[k] ? -mag : mag;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl_ff[NST].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_ff[NST].singular) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff.sol_x     <= sol_in[0];
         rsp_ff.sol_y     <= sol_in[1];
         rsp_ff.sol_z     <= sol_in[2];
         rsp_ff.solvable  <= 1'b1;
         rsp_ff.saturated <= |sat_in;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

>>> hw/rtl/linear_solve_3x3.sv
// top level of the 3x3 linear solver by Cramer's rule
// One system is taken per clock while busy is low; its result appears on
// rsp_data with rsp_strobe for one cycle, and results leave in request order.
// The result passes the four front-end stages (request capture, two multiplies
// and the sum), one queue stage and the 33-stage divider lanes (a setup stage
// and then one quotient bit per stage) and the result register. The receiver
// cannot stall, so the queue drains every cycle and busy stays low in normal use.
// The singularity threshold may be written only while no request is in flight.
module linear_solve_3x3 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lss_pkg::req_type          req_data,
   output logic                      rsp_strobe,
   output lss_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [lss_pkg::THR_W-1:0] csr_wdata
);

   logic [lss_pkg::THR_W-1:0] thr_ff;
   logic                      front_valid;
   lss_pkg::job_type          front_job;
   logic                      q_not_empty, q_full;
   lss_pkg::job_type          q_head;

   // singularity threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= lss_pkg::THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign busy = q_full;

   lss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .threshold (thr_ff),
      .out_valid (front_valid),
      .out_job   (front_job)
   );

   lss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_job  (front_job),
      .pop       (1'b1),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head_job  (q_head)
   );

   lss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_not_empty),
      .in_job     (q_head),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_data)
   );

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.solvable) |->
         (rsp_data.sol_x == '0 && rsp_data.sol_y == '0 && rsp_data.sol_z == '0
          && !rsp_data.saturated))
      else $error("singular result not cleared");

   a_sat_solvable: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.saturated) |-> rsp_data.solvable)
      else $error("saturation flagged on singular result");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy) else $error("queue filled although back end drains every cycle");

endmodule
